>>> src/assert_macros.svh
// assertion helpers for the list unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a implies b at each clock edge
`define ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);
// check that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);
`endif

>>> src/dllc_pkg.sv
// -----------------------------------------------------------------------------
// dllc_pkg: shared types and codes
// operation codes and controller/datapath command types of the list unit
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dllc_pkg;
  typedef enum logic [4:0] {
    OP_CLEAR = 5'd0, OP_INS_FIRST = 5'd1, OP_INS_LAST = 5'd2, OP_CUR_FIRST = 5'd3,
    OP_CUR_LAST = 5'd4, OP_RD_FIRST = 5'd5, OP_RD_LAST = 5'd6, OP_DEL_FIRST = 5'd7,
    OP_DEL_LAST = 5'd8, OP_POST_DEL = 5'd9, OP_PRE_DEL = 5'd10, OP_POST_INS = 5'd11,
    OP_PRE_INS = 5'd12, OP_RD_CUR = 5'd13, OP_WR_CUR = 5'd14, OP_NEXT = 5'd15,
    OP_PREV = 5'd16
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture request
    logic rd1;    // first pointer fetch
    logic rd2;    // second pointer fetch
    logic exec;   // commit updates
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dummy_ok;
  } dp_sts_t;
endpackage
`default_nettype wire

>>> src/dllc_if.sv
// -----------------------------------------------------------------------------
// dllc_req_if / dllc_rsp_if: valid/ready channels
// request and response channels of the list unit
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dllc_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic signed [31:0] value;
  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface dllc_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] read_value;
  logic        error;
  logic        cursor_active;
  modport source (output valid, read_value, error, cursor_active, input ready);
  modport sink (input valid, read_value, error, cursor_active, output ready);
endinterface
`default_nettype wire

>>> src/doubly_linked_list_with_cursor_unit.sv
// -----------------------------------------------------------------------------
// Doubly linked list with cursor over a pool of POOL_NODES nodes.
// Requests arrive on the in channel (kind, value) with valid/ready; each
// request produces exactly one response on the out channel (read_value,
// error, cursor_active).
// A request is taken only when no earlier response is pending. It then
// fetches the anchor node, then its neighbor, and then commits pool and
// pointer updates; the response is presented in the next cycle. A new
// request is taken only after the previous response has been accepted.
// If the receiver stalls, the response holds and no new request is taken.
// Reset clears the list, cursor, free list and fresh-node count; the pool
// contents are not cleared and need no clearing pass.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module doubly_linked_list_with_cursor_unit #(
  parameter int POOL_NODES = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  dllc_req_if.sink   in_ch,
  dllc_rsp_if.source out_ch
);
  import dllc_pkg::*;
  dp_cmd_t cmd;
  dp_sts_t sts;

  dllc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  dllc_dp #(.POOL_NODES(POOL_NODES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_ch.kind), .in_value(in_ch.value),
    .out_read_value(out_ch.read_value), .out_error(out_ch.error),
    .out_cursor_active(out_ch.cursor_active)
  );

  // checks
  `ASSERT_IMPL(a_no_take_while_out, clk, rst_n, out_ch.valid, !in_ch.ready,
    "request taken while response pending")
  `ASSERT_NEXT(a_exec_then_out, clk, rst_n, cmd.exec, out_ch.valid,
    "commit not followed by response")
  `ASSERT_NEXT(a_load_then_fetch, clk, rst_n, cmd.load, cmd.rd1,
    "transfer not followed by fetch")
endmodule
`default_nettype wire

>>> src/dllc_ctrl.sv
// -----------------------------------------------------------------------------
// dllc_ctrl: request sequencer
// steps each request through capture, two pointer fetches and commit
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dllc_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dllc_pkg::dp_cmd_t cmd,
  input  dllc_pkg::dp_sts_t sts
);
  import dllc_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_EXEC, S_OUT} state_t;
  state_t state_r;
  logic   unused_sts;
  assign unused_sts = sts.dummy_ok;

  // accept only when idle, with no request in progress and no result pending
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.rd1  = (state_r == S_RD1);
    cmd.rd2  = (state_r == S_RD2);
    cmd.exec = (state_r == S_EXEC);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_RD1;
        S_RD1:  state_r <= S_RD2;
        S_RD2:  state_r <= S_EXEC;
        S_EXEC: state_r <= S_OUT;
        S_OUT:  if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/dllc_dp.sv
// -----------------------------------------------------------------------------
// dllc_dp: list datapath
// node pool memories, list pointers and the result register
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dllc_dp #(
  parameter int POOL_NODES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  dllc_pkg::dp_cmd_t cmd,
  output dllc_pkg::dp_sts_t sts,
  input  wire logic [4:0] in_kind,
  input  wire logic signed [31:0] in_value,
  output logic signed [31:0] out_read_value,
  output logic out_error,
  output logic out_cursor_active
);
  import dllc_pkg::*;
  localparam int IW = $clog2(POOL_NODES + 1);
  localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam logic [IW-1:0] NIL = IW'(POOL_NODES);
  typedef logic [IW-1:0] idx_t;

  logic [31:0] mem_val [POOL_NODES];
  idx_t        mem_nxt [POOL_NODES];
  idx_t        mem_prv [POOL_NODES];

  idx_t head_r, tail_r, cur_r, free_r, fresh_r;
  logic [4:0] kind_r;
  logic [31:0] v_r;
  logic [31:0] rv_r;
  logic err_r;
  // fetched node fields
  idx_t a_nxt_r, a_prv_r, b_nxt_r, b_prv_r, f_nxt_r;
  logic [31:0] a_val_r;

  function automatic logic okf(idx_t i);
    return i < NIL;
  endfunction

  assign sts.dummy_ok = okf(cur_r);
  assign out_read_value = rv_r;
  assign out_error = err_r;
  assign out_cursor_active = okf(cur_r);

  // first fetch node: the one the operation is anchored on
  idx_t a_idx;
  always_comb begin
    case (kind_r)
      OP_RD_FIRST, OP_DEL_FIRST: a_idx = head_r;
      OP_RD_LAST, OP_DEL_LAST:   a_idx = tail_r;
      default:                   a_idx = cur_r;
    endcase
  end
  // second fetch node: neighbor of the first
  idx_t b_idx;
  assign b_idx = (kind_r == OP_PRE_DEL) ? a_prv_r : a_nxt_r;

  // memory reads, registered
  always_ff @(posedge clk) begin
    if (cmd.rd1) begin
      if (okf(a_idx)) begin
        a_nxt_r <= mem_nxt[a_idx[AW-1:0]];
        a_prv_r <= mem_prv[a_idx[AW-1:0]];
        a_val_r <= mem_val[a_idx[AW-1:0]];
      end else begin
        a_nxt_r <= NIL;
        a_prv_r <= NIL;
        a_val_r <= '0;
      end
      f_nxt_r <= okf(free_r) ? mem_nxt[free_r[AW-1:0]] : NIL;
    end
    if (cmd.rd2) begin
      b_nxt_r <= okf(b_idx) ? mem_nxt[b_idx[AW-1:0]] : NIL;
      b_prv_r <= okf(b_idx) ? mem_prv[b_idx[AW-1:0]] : NIL;
    end
  end

  // allocation
  idx_t alloc;
  always_comb begin
    if (okf(free_r)) alloc = free_r;
    else if (fresh_r < NIL) alloc = fresh_r;
    else alloc = NIL;
  end

  // commit: up to three node writes plus pointer updates
  logic w0_en, w1n_en, w1p_en, w2n_en, w2p_en, wv_en;
  idx_t w0_idx, w1_idx, w2_idx, w0_nxt, w0_prv, w1n_d, w1p_d, w2n_d, w2p_d;
  logic [31:0] wv_d;
  idx_t head_nxt, tail_nxt, cur_nxt, free_nxt, fresh_nxt;
  logic [31:0] rv_nxt;
  logic err_nxt;
  logic use_alloc;

  always_comb begin
    w0_en = 1'b0; w0_idx = alloc; w0_nxt = NIL; w0_prv = NIL;
    w1n_en = 1'b0; w1p_en = 1'b0; w1_idx = NIL; w1n_d = NIL; w1p_d = NIL;
    w2n_en = 1'b0; w2p_en = 1'b0; w2_idx = NIL; w2n_d = NIL; w2p_d = NIL;
    wv_en = 1'b0; wv_d = v_r;
    head_nxt = head_r; tail_nxt = tail_r; cur_nxt = cur_r;
    free_nxt = free_r; fresh_nxt = fresh_r;
    rv_nxt = '0; err_nxt = 1'b0; use_alloc = 1'b0;
    case (kind_r)
      OP_CLEAR: begin
        if (okf(head_r)) begin
          w1n_en = 1'b1; w1_idx = tail_r; w1n_d = free_r; free_nxt = head_r;
        end
        head_nxt = NIL; tail_nxt = NIL; cur_nxt = NIL;
      end
      OP_INS_FIRST: begin
        if (!okf(alloc)) err_nxt = 1'b1;
        else begin
          use_alloc = 1'b1; w0_en = 1'b1; w0_prv = NIL; w0_nxt = head_r;
          if (okf(head_r)) begin
            w1p_en = 1'b1; w1_idx = head_r; w1p_d = alloc;
          end else tail_nxt = alloc;
          head_nxt = alloc;
        end
      end
      OP_INS_LAST: begin
        if (!okf(alloc)) err_nxt = 1'b1;
        else begin
          use_alloc = 1'b1; w0_en = 1'b1; w0_prv = tail_r; w0_nxt = NIL;
          if (okf(tail_r)) begin
            w1n_en = 1'b1; w1_idx = tail_r; w1n_d = alloc;
          end else head_nxt = alloc;
          tail_nxt = alloc;
        end
      end
      OP_CUR_FIRST: cur_nxt = head_r;
      OP_CUR_LAST:  cur_nxt = tail_r;
      OP_RD_FIRST, OP_RD_LAST, OP_RD_CUR: begin
        if (!okf(a_idx)) err_nxt = 1'b1; else rv_nxt = a_val_r;
      end
      OP_DEL_FIRST: begin
        if (okf(head_r)) begin
          if (cur_r == head_r) cur_nxt = NIL;
          if (okf(a_nxt_r)) begin
            w1p_en = 1'b1; w1_idx = a_nxt_r; w1p_d = NIL;
          end else tail_nxt = NIL;
          w2n_en = 1'b1; w2_idx = head_r; w2n_d = free_r; free_nxt = head_r;
          head_nxt = a_nxt_r;
        end
      end
      OP_DEL_LAST: begin
        if (okf(tail_r)) begin
          if (cur_r == tail_r) cur_nxt = NIL;
          if (okf(a_prv_r)) begin
            w1n_en = 1'b1; w1_idx = a_prv_r; w1n_d = NIL;
          end else head_nxt = NIL;
          w2n_en = 1'b1; w2_idx = tail_r; w2n_d = free_r; free_nxt = tail_r;
          tail_nxt = a_prv_r;
        end
      end
      OP_POST_DEL: begin
        if (okf(cur_r) && cur_r != tail_r && okf(a_nxt_r)) begin
          w1n_en = 1'b1; w1_idx = cur_r; w1n_d = b_nxt_r;
          if (okf(b_nxt_r)) begin
            w1p_en = 1'b0; // prev of u set below via u fixup slot
            w0_en = 1'b0;
          end else tail_nxt = cur_r;
          w2n_en = 1'b1; w2_idx = a_nxt_r; w2n_d = free_r; free_nxt = a_nxt_r;
        end
      end
      OP_PRE_DEL: begin
        if (okf(cur_r) && cur_r != head_r && okf(a_prv_r)) begin
          w1p_en = 1'b1; w1_idx = cur_r; w1p_d = b_prv_r;
          if (!okf(b_prv_r)) head_nxt = cur_r;
          w2n_en = 1'b1; w2_idx = a_prv_r; w2n_d = free_r; free_nxt = a_prv_r;
        end
      end
      OP_POST_INS: begin
        if (okf(cur_r)) begin
          if (!okf(alloc)) err_nxt = 1'b1;
          else begin
            use_alloc = 1'b1; w0_en = 1'b1; w0_prv = cur_r; w0_nxt = a_nxt_r;
            w1n_en = 1'b1; w1_idx = cur_r; w1n_d = alloc;
            if (okf(a_nxt_r)) begin
              w2p_en = 1'b1; w2_idx = a_nxt_r; w2p_d = alloc;
            end else tail_nxt = alloc;
          end
        end
      end
      OP_PRE_INS: begin
        if (okf(cur_r)) begin
          if (!okf(alloc)) err_nxt = 1'b1;
          else begin
            use_alloc = 1'b1; w0_en = 1'b1; w0_prv = a_prv_r; w0_nxt = cur_r;
            w1p_en = 1'b1; w1_idx = cur_r; w1p_d = alloc;
            if (okf(a_prv_r)) begin
              w2n_en = 1'b1; w2_idx = a_prv_r; w2n_d = alloc;
            end else head_nxt = alloc;
          end
        end
      end
      OP_WR_CUR: if (okf(cur_r)) wv_en = 1'b1;
      OP_NEXT: if (okf(cur_r)) cur_nxt = a_nxt_r;
      OP_PREV: if (okf(cur_r)) cur_nxt = a_prv_r;
      default: ;
    endcase
    if (use_alloc) begin
      if (okf(free_r)) free_nxt = f_nxt_r;
      else fresh_nxt = fresh_r + 1'b1;
    end
  end

  // third-slot fixup for post/pre delete: prev of u or next of u
  logic u_en;
  idx_t u_idx;
  logic u_is_prev;
  always_comb begin
    u_en = 1'b0; u_idx = b_nxt_r; u_is_prev = 1'b1;
    if (kind_r == OP_POST_DEL && okf(cur_r) && cur_r != tail_r && okf(a_nxt_r)
        && okf(b_nxt_r)) begin
      u_en = 1'b1; u_idx = b_nxt_r; u_is_prev = 1'b1;
    end else if (kind_r == OP_PRE_DEL && okf(cur_r) && cur_r != head_r
        && okf(a_prv_r) && okf(b_prv_r)) begin
      u_en = 1'b1; u_idx = b_prv_r; u_is_prev = 1'b0;
    end
  end

  // pool writes
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (w0_en && okf(w0_idx)) begin
        mem_val[w0_idx[AW-1:0]] <= v_r;
        mem_nxt[w0_idx[AW-1:0]] <= w0_nxt;
        mem_prv[w0_idx[AW-1:0]] <= w0_prv;
      end
      if (wv_en) mem_val[cur_r[AW-1:0]] <= wv_d;
      if (w1n_en && okf(w1_idx)) mem_nxt[w1_idx[AW-1:0]] <= w1n_d;
      if (w1p_en && okf(w1_idx)) mem_prv[w1_idx[AW-1:0]] <= w1p_d;
      if (w2n_en && okf(w2_idx)) mem_nxt[w2_idx[AW-1:0]] <= w2n_d;
      if (w2p_en && okf(w2_idx)) mem_prv[w2_idx[AW-1:0]] <= w2p_d;
      if (u_en) begin
        if (u_is_prev) mem_prv[u_idx[AW-1:0]] <= cur_r;
        else mem_nxt[u_idx[AW-1:0]] <= cur_r;
      end
    end
  end

  // request capture and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      v_r <= in_value;
    end
    if (cmd.exec) begin
      rv_r <= rv_nxt;
      err_r <= err_nxt;
    end
  end

  // list pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL; tail_r <= NIL; cur_r <= NIL; free_r <= NIL; fresh_r <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt; tail_r <= tail_nxt; cur_r <= cur_nxt;
      free_r <= free_nxt; fresh_r <= fresh_nxt;
    end
  end
endmodule
`default_nettype wire
